// ----- rtl/ptaq_pkg.sv -----
package ptaq_pkg;

  // Waiter queue geometry
  localparam int WAIT_DEPTH = 16;
  localparam int WAIT_AW    = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int CNT_W      = $clog2(WAIT_DEPTH + 1);

  // Requester ids keep only this many low bits
  localparam int ID_BITS = 8;

  // Field widths fixed by the interface
  localparam int REQ_ID_W = 8;
  localparam int TOKEN_W  = 10;

  localparam logic [TOKEN_W-1:0] MAX_INFLIGHT_RST = TOKEN_W'(16);

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_GRANTED = 3'd0,
    ST_QUEUED  = 3'd1,
    ST_DROPPED = 3'd2,
    ST_FULL    = 3'd3,
    ST_FREED   = 3'd4,
    ST_HANDED  = 3'd5,
    ST_REL_ERR = 3'd6
  } status_t;

  typedef struct packed {
    logic                op;
    logic                read_ahead;
    logic [REQ_ID_W-1:0] requester_id;
  } in_req_t;

  typedef struct packed {
    status_t             status;
    logic [REQ_ID_W-1:0] granted_id;
    logic [TOKEN_W-1:0]  tokens_held;
  } out_rsp_t;

  // Admission logic -> waiter queue
  typedef struct packed {
    logic               push;
    logic               pop;
    logic [ID_BITS-1:0] push_id;
  } fifo_ctl_t;

  // Waiter queue -> admission logic
  typedef struct packed {
    logic               empty;
    logic               full;
    logic [ID_BITS-1:0] head_id;
  } fifo_sts_t;

endpackage

// ----- rtl/ptaq_wait_fifo.sv -----
module ptaq_wait_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  ptaq_pkg::fifo_ctl_t ctl,
  output ptaq_pkg::fifo_sts_t sts
);
  import ptaq_pkg::*;

  logic [ID_BITS-1:0] ids_r [WAIT_DEPTH];
  logic [WAIT_AW-1:0] head_r, head_nxt;
  logic [WAIT_AW-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  // Pointer advance with wrap at the queue depth
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (ctl.pop) begin
      head_nxt = (head_r == WAIT_AW'(WAIT_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (ctl.push) begin
      tail_nxt = (tail_r == WAIT_AW'(WAIT_DEPTH - 1)) ? '0 : tail_r + 1'b1;
    end
    case ({ctl.push, ctl.pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Id storage, no reset: entries are read only after being written
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      ids_r[tail_r] <= ctl.push_id;
    end
  end

  assign sts.empty   = (cnt_r == '0);
  assign sts.full    = (cnt_r == CNT_W'(WAIT_DEPTH));
  assign sts.head_id = ids_r[head_r];

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> !sts.full) else $error("push into full waiter queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> !sts.empty) else $error("pop from empty waiter queue");

  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.push && !ctl.pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("waiter count did not follow push");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (sts.empty || sts.full) |-> (head_r == tail_r))
    else $error("pointers disagree with count");
`endif

endmodule

// ----- rtl/ptaq_admit.sv -----
module ptaq_admit (
  input  logic                                fire,
  input  ptaq_pkg::in_req_t                   req,
  input  logic [ptaq_pkg::TOKEN_W-1:0]        tokens,
  input  logic [ptaq_pkg::TOKEN_W-1:0]        max_inflight,
  input  ptaq_pkg::fifo_sts_t                 fsts,
  output ptaq_pkg::fifo_ctl_t                 fctl,
  output logic [ptaq_pkg::TOKEN_W-1:0]        tokens_nxt,
  output ptaq_pkg::out_rsp_t                  rsp
);
  import ptaq_pkg::*;

  logic [TOKEN_W:0]   tokens_inc;
  logic               grant;
  logic [ID_BITS-1:0] req_id;

  assign tokens_inc = {1'b0, tokens} + 1'b1;
  assign req_id     = req.requester_id[ID_BITS-1:0];

  // Low priority needs two free tokens and an empty queue
  assign grant = req.read_ahead ? ((tokens_inc < {1'b0, max_inflight}) && fsts.empty)
                                : (tokens < max_inflight);

  always_comb begin
    fctl.push    = 1'b0;
    fctl.pop     = 1'b0;
    fctl.push_id = req_id;
    tokens_nxt   = tokens;
    rsp.status   = ST_REL_ERR;
    rsp.granted_id = '0;
    case (req.op)
      OP_ACQUIRE: begin
        if (grant) begin
          tokens_nxt     = tokens_inc[TOKEN_W-1:0];
          rsp.status     = ST_GRANTED;
          rsp.granted_id = REQ_ID_W'(req_id);
        end else if (req.read_ahead) begin
          rsp.status = ST_DROPPED;
        end else if (fsts.full) begin
          rsp.status = ST_FULL;
        end else begin
          fctl.push  = fire;
          rsp.status = ST_QUEUED;
        end
      end
      OP_RELEASE: begin
        if (tokens == '0) begin
          rsp.status = ST_REL_ERR;
        end else if (!fsts.empty) begin
          // token passes straight to the oldest waiter
          fctl.pop       = fire;
          rsp.status     = ST_HANDED;
          rsp.granted_id = REQ_ID_W'(fsts.head_id);
        end else begin
          tokens_nxt = tokens - 1'b1;
          rsp.status = ST_FREED;
        end
      end
      default: begin
        rsp.status = ST_REL_ERR;
      end
    endcase
    rsp.tokens_held = tokens_nxt;
  end

endmodule

// ----- rtl/priority_token_admission_queue_top.sv -----
// Pipeline: a request accepted into the input register moves on to the result
//   register when that register is free, and its result is offered from there.
// Throughput: one request per cycle while out_stall is low; the input register
//   and the result register each hold one request.
// Reset (rst_n low, synchronous): tokens in use, queue pointers and valid flags
//   clear, max_inflight returns to 16; waiter id storage is not cleared.
module priority_token_admission_queue_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ptaq_pkg::in_req_t             in_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ptaq_pkg::out_rsp_t            out_rsp,
  input  logic                          cfg_we,
  input  logic [ptaq_pkg::TOKEN_W-1:0]  cfg_wdata
);
  import ptaq_pkg::*;

  logic               in_valid_r;
  in_req_t            in_req_r;
  logic               out_valid_r;
  out_rsp_t           out_rsp_r;
  logic [TOKEN_W-1:0] tokens_r, tokens_nxt;
  logic [TOKEN_W-1:0] max_r;
  logic               adv;
  logic               fire;
  out_rsp_t           rsp;
  fifo_ctl_t          fctl;
  fifo_sts_t          fsts;

  // Result register frees up when empty or taken
  assign adv      = !out_valid_r || !out_stall;
  assign fire     = adv && in_valid_r;
  assign in_stall = in_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tokens_r    <= '0;
      max_r       <= MAX_INFLIGHT_RST;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
      end
      if (fire) begin
        tokens_r <= tokens_nxt;
      end
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_req_r <= in_req;
    end
    if (fire) begin
      out_rsp_r <= rsp;
    end
  end

  ptaq_admit u_admit (
    .fire         (fire),
    .req          (in_req_r),
    .tokens       (tokens_r),
    .max_inflight (max_r),
    .fsts         (fsts),
    .fctl         (fctl),
    .tokens_nxt   (tokens_nxt),
    .rsp          (rsp)
  );

  ptaq_wait_fifo u_wait_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (fctl),
    .sts   (fsts)
  );

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

`ifndef SYNTHESIS
  a_tokens_match: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (out_rsp_r.tokens_held == tokens_r))
    else $error("reported tokens differ from token counter");

  a_handoff_keeps_tokens: assert property (@(posedge clk) disable iff (!rst_n)
    fctl.pop |=> (tokens_r == $past(tokens_r)))
    else $error("token count changed on handoff to waiter");

  a_fifo_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |-> (!fctl.push && !fctl.pop))
    else $error("waiter queue moved without a request");
`endif

endmodule

// ----- tb/priority_token_admission_queue_top_test.sv -----
`timescale 1ns / 1ps

module priority_token_admission_queue_top_test;
  import ptaq_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int RSP_LATENCY = 2;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_rsp_t out_rsp;
  logic cfg_we = 1'b0;
  logic [TOKEN_W-1:0] cfg_wdata = '0;

  // Predicted admission state
  logic [TOKEN_W-1:0] budget;
  logic [TOKEN_W-1:0] tokens_out;
  logic [ID_BITS-1:0] waiter_fifo[$];

  // Responses owed by the block, oldest first
  out_rsp_t due_rsp[$];

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_cnt = 0;
  int quiet_cycles = 0;

  priority_token_admission_queue_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one request to the predicted state and return the response it earns
  function automatic out_rsp_t predict_admission(in_req_t r);
    out_rsp_t rsp;
    logic grant;
    rsp = '0;
    if (r.op == OP_ACQUIRE) begin
      // low priority needs two free tokens and an empty waiter queue
      if (r.read_ahead)
        grant = (int'(tokens_out) + 1 < int'(budget)) && (waiter_fifo.size() == 0);
      else
        grant = tokens_out < budget;
      if (grant) begin
        tokens_out = tokens_out + 1'b1;
        rsp.status = ST_GRANTED;
        rsp.granted_id = REQ_ID_W'(r.requester_id[ID_BITS-1:0]);
      end else if (r.read_ahead) begin
        rsp.status = ST_DROPPED;
      end else if (waiter_fifo.size() >= WAIT_DEPTH) begin
        rsp.status = ST_FULL;
      end else begin
        waiter_fifo.push_back(r.requester_id[ID_BITS-1:0]);
        rsp.status = ST_QUEUED;
      end
    end else if (tokens_out == '0) begin
      rsp.status = ST_REL_ERR;
    end else if (waiter_fifo.size() != 0) begin
      // token passes straight to the oldest waiter, count unchanged
      rsp.status = ST_HANDED;
      rsp.granted_id = REQ_ID_W'(waiter_fifo.pop_front());
    end else begin
      tokens_out = tokens_out - 1'b1;
      rsp.status = ST_FREED;
    end
    rsp.tokens_held = tokens_out;
    return rsp;
  endfunction

  // Offer one request, with optional idle cycles ahead of it
  task automatic send_req(input logic op, input logic low, input logic [REQ_ID_W-1:0] id);
    in_req_t r;
    r.op = op;
    r.read_ahead = low;
    r.requester_id = id;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    due_rsp.push_back(predict_admission(r));
  endtask

  // Hold off the input until every owed response has come back
  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_rsp.size() != 0);
  endtask

  // Budget writes only happen with the block idle
  task automatic write_budget(input logic [TOKEN_W-1:0] value);
    wait_results_done();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    budget = value;
  endtask

  // Reset budget: grants of both priorities, frees, release with nothing held
  task automatic test_default_budget();
    send_req(OP_ACQUIRE, 1'b0, 8'h00);
    send_req(OP_ACQUIRE, 1'b1, 8'hFF);
    send_req(OP_RELEASE, 1'b1, 8'hFF);
    send_req(OP_RELEASE, 1'b0, 8'h00);
    send_req(OP_RELEASE, 1'b0, 8'h5A);
  endtask

  // Zero budget: demand requests queue until full, low priority drops,
  // release errors out even with waiters queued
  task automatic test_zero_budget();
    write_budget('0);
    for (int i = 0; i < WAIT_DEPTH; i++)
      send_req(OP_ACQUIRE, 1'b0, REQ_ID_W'(i * 17));
    send_req(OP_ACQUIRE, 1'b0, 8'hFF);
    send_req(OP_ACQUIRE, 1'b1, 8'h80);
    send_req(OP_RELEASE, 1'b0, 8'h00);
  endtask

  // Free capacity beats waiters; budget dropped below tokens held
  task automatic test_budget_changes();
    write_budget(10'h3FF);
    send_req(OP_ACQUIRE, 1'b0, 8'h7F);
    send_req(OP_ACQUIRE, 1'b0, 8'h01);
    send_req(OP_RELEASE, 1'b0, 8'h33);
    write_budget(10'd1);
    send_req(OP_ACQUIRE, 1'b0, 8'hC3);
    send_req(OP_ACQUIRE, 1'b1, 8'h3C);
    send_req(OP_RELEASE, 1'b1, 8'hAA);
  endtask

  // Random mix in three budget settings under one idling pattern
  task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int n_req);
    int acq_pct;
    int low_pct;
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    for (int blk = 0; blk < 3; blk++) begin
      case ($urandom_range(3))
        0: begin
          write_budget(10'd1);
        end
        1: begin
          write_budget(10'h3FF);
        end
        default: begin
          write_budget(TOKEN_W'($urandom_range(2, 24)));
        end
      endcase
      acq_pct = $urandom_range(40, 75);
      low_pct = $urandom_range(10, 50);
      for (int k = 0; k < n_req / 3; k++) begin
        if ($urandom_range(63) == 0) wait_results_done();
        send_req(($urandom_range(99) < acq_pct) ? OP_ACQUIRE : OP_RELEASE,
                 $urandom_range(99) < low_pct, REQ_ID_W'($urandom));
      end
    end
  endtask

  // Response checker, receiver stalls and watchdog
  always @(posedge clk) begin
    out_rsp_t want;
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (rst_n) begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("priority_token_admission_queue_top_test: done, errors");
        $finish;
      end
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (due_rsp.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("unexpected response: status %0d id %02h held %0d",
                     out_rsp.status, out_rsp.granted_id, out_rsp.tokens_held);
        end else begin
          want = due_rsp.pop_front();
          if (want.status !== out_rsp.status || want.granted_id !== out_rsp.granted_id ||
              want.tokens_held !== out_rsp.tokens_held) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("mismatch: expected status %0d id %02h held %0d, got %0d %02h %0d",
                       want.status, want.granted_id, want.tokens_held,
                       out_rsp.status, out_rsp.granted_id, out_rsp.tokens_held);
          end
        end
      end
    end
  end

  initial begin
    budget = MAX_INFLIGHT_RST;
    tokens_out = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_budget();
    test_zero_budget();
    test_budget_changes();
    test_random_traffic(0, 0, 300);
    test_random_traffic(50, 0, 300);
    test_random_traffic(0, 50, 300);
    test_random_traffic(29, 29, 300);

    wait_results_done();
    repeat (RSP_LATENCY + 2) @(posedge clk);
    if (mismatch_cnt == 0 && due_rsp.size() == 0)
      $display("priority_token_admission_queue_top_test: done, clean");
    else
      $display("priority_token_admission_queue_top_test: done, errors");
    $finish;
  end

endmodule
